### rtl/bcd_pkg.sv
package bcd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DEPTH_BITS = 16;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DZ_W   = DEPTH_BITS + 1;
  localparam int WP_W   = SUM_W + DZ_W;
  localparam int NUM_W  = WP_W + 1;
  localparam int QUOT_W = DEPTH_BITS + 2;
  localparam int DSH_W  = SUM_W + QUOT_W - 1;
  localparam int VAL_W  = QUOT_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEPTH_BITS-1:0] depth_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [WP_W-1:0]       wprod_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic        [NUM_W-1:0]      mag_t;
  typedef logic        [SUM_W-1:0]      dmag_t;
  typedef logic        [DSH_W-1:0]      dsh_t;
  typedef logic        [QUOT_W-1:0]     quot_t;
  typedef logic signed [VAL_W-1:0]      sval_t;

  localparam quot_t Q_CAP = quot_t'(1) << (DEPTH_BITS + 1);
  localparam sval_t D_MAX = (sval_t'(1) <<< (DEPTH_BITS - 1)) - sval_t'(1);
  localparam sval_t D_MIN = -D_MAX - sval_t'(1);

  typedef struct packed {
    logic   deg;
    logic   neg;
    logic   ovf;
    depth_t z2;
    mag_t   rem;
    dsh_t   dsh;
    quot_t  q;
  } div_item_t;

  function automatic diff_t sdiff(input coord_t a, input coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

endpackage

### rtl/bcd_in_if.sv
interface bcd_in_if import bcd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex0_x;
  coord_t vertex0_y;
  depth_t vertex0_z;
  coord_t vertex1_x;
  coord_t vertex1_y;
  depth_t vertex1_z;
  coord_t vertex2_x;
  coord_t vertex2_y;
  depth_t vertex2_z;
  coord_t point_x;
  coord_t point_y;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, point_x, point_y,
    output ready
  );
endinterface

### rtl/bcd_out_if.sv
interface bcd_out_if import bcd_pkg::*; ();
  logic   valid;
  logic   ready;
  depth_t depth_value;
  logic   degenerate;

  modport source (output valid, depth_value, degenerate, input ready);
  modport sink (input valid, depth_value, degenerate, output ready);
endinterface

### rtl/barycentric_depth_interpolation.sv
// Channel    Direction  Payload
// in_chan    sink       three vertices (x, y, z) and query point (x, y)
// out_chan   source     depth_value, degenerate
//
// One request is accepted per cycle unless a stall at the output has filled the stages; results leave in order.
// The pipeline is seven arithmetic stages, one division cell per quotient bit
// (eighteen) and the output register.
// Reset is synchronous and active low and clears only the valid bits of the stages.
// A stall at the output fills empty stages first, so requests keep flowing until full.
module barycentric_depth_interpolation import bcd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  bcd_in_if.sink    in_chan,
  bcd_out_if.source out_chan
);

  logic      cv   [0:QUOT_W];
  logic      crdy [0:QUOT_W];
  div_item_t citem[0:QUOT_W];

  bcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .dn_valid (cv[0]),
    .dn_ready (crdy[0]),
    .dn_item  (citem[0])
  );

  for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
    bcd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_ready (crdy[k]),
      .up_item  (citem[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (crdy[k+1]),
      .dn_item  (citem[k+1])
    );
  end

  bcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cv[QUOT_W]),
    .up_ready (crdy[QUOT_W]),
    .up_item  (citem[QUOT_W]),
    .out_chan (out_chan)
  );

endmodule

### rtl/bcd_front.sv
module bcd_front import bcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bcd_in_if.sink    in_chan,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_item_t dn_item
);

  localparam int NS = 7;

  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;

  diff_t  a_r, b_r, c_r, e_r, f_r, g_r, h_r, dz0_1_r, dz1_1_r;
  depth_t z2_1_r, z2_2_r, z2_3_r, z2_4_r, z2_5_r, z2_6_r;
  prod_t  pae_r, pbh_r, paf_r, pbg_r, pcf_r, peg_r;
  diff_t  dz0_2_r, dz1_2_r, dz0_3_r, dz1_3_r;
  sum_t   den_r, n1_r, n2_r, den_4_r;
  wprod_t w1_r, w2_r;
  num_t   num_r;
  dmag_t  dmag_5_r, dmag_6_r;
  logic   dneg_5_r, deg_5_r, deg_6_r, neg_6_r;
  mag_t   nmag_r;
  div_item_t item_r;

  always_comb begin
    rdy[NS+1] = dn_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_chan.ready = rdy[1];
  assign dn_valid      = v_r[NS];
  assign dn_item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_chan.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      a_r     <= sdiff(in_chan.vertex1_y, in_chan.vertex2_y);
      b_r     <= sdiff(in_chan.vertex2_x, in_chan.vertex1_x);
      c_r     <= sdiff(in_chan.vertex2_y, in_chan.vertex0_y);
      e_r     <= sdiff(in_chan.vertex0_x, in_chan.vertex2_x);
      f_r     <= sdiff(in_chan.point_x, in_chan.vertex2_x);
      g_r     <= sdiff(in_chan.point_y, in_chan.vertex2_y);
      h_r     <= sdiff(in_chan.vertex0_y, in_chan.vertex2_y);
      dz0_1_r <= diff_t'(in_chan.vertex0_z) - diff_t'(in_chan.vertex2_z);
      dz1_1_r <= diff_t'(in_chan.vertex1_z) - diff_t'(in_chan.vertex2_z);
      z2_1_r  <= in_chan.vertex2_z;
    end
    if (rdy[2]) begin
      pae_r   <= prod_t'(a_r) * prod_t'(e_r);
      pbh_r   <= prod_t'(b_r) * prod_t'(h_r);
      paf_r   <= prod_t'(a_r) * prod_t'(f_r);
      pbg_r   <= prod_t'(b_r) * prod_t'(g_r);
      pcf_r   <= prod_t'(c_r) * prod_t'(f_r);
      peg_r   <= prod_t'(e_r) * prod_t'(g_r);
      dz0_2_r <= dz0_1_r;
      dz1_2_r <= dz1_1_r;
      z2_2_r  <= z2_1_r;
    end
    if (rdy[3]) begin
      den_r   <= sum_t'(pae_r) + sum_t'(pbh_r);
      n1_r    <= sum_t'(paf_r) + sum_t'(pbg_r);
      n2_r    <= sum_t'(pcf_r) + sum_t'(peg_r);
      dz0_3_r <= dz0_2_r;
      dz1_3_r <= dz1_2_r;
      z2_3_r  <= z2_2_r;
    end
    if (rdy[4]) begin
      w1_r    <= wprod_t'(n1_r) * wprod_t'(dz0_3_r);
      w2_r    <= wprod_t'(n2_r) * wprod_t'(dz1_3_r);
      den_4_r <= den_r;
      z2_4_r  <= z2_3_r;
    end
    if (rdy[5]) begin
      num_r    <= num_t'(w1_r) + num_t'(w2_r);
      dmag_5_r <= dmag_t'(den_4_r[SUM_W-1] ? -den_4_r : den_4_r);
      dneg_5_r <= den_4_r[SUM_W-1];
      deg_5_r  <= (den_4_r == '0);
      z2_5_r   <= z2_4_r;
    end
    if (rdy[6]) begin
      nmag_r   <= mag_t'(num_r[NUM_W-1] ? -num_r : num_r);
      neg_6_r  <= num_r[NUM_W-1] ^ dneg_5_r;
      dmag_6_r <= dmag_5_r;
      deg_6_r  <= deg_5_r;
      z2_6_r   <= z2_5_r;
    end
    if (rdy[7]) begin
      item_r.deg <= deg_6_r;
      item_r.neg <= neg_6_r;
      item_r.ovf <= (nmag_r >= {dmag_6_r, QUOT_W'(0)});
      item_r.z2  <= z2_6_r;
      item_r.rem <= nmag_r;
      item_r.dsh <= {dmag_6_r, (QUOT_W-1)'(0)};
      item_r.q   <= '0;
    end
  end

endmodule

### rtl/bcd_div_cell.sv
module bcd_div_cell import bcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_item_t dn_item
);

  logic      valid_r;
  div_item_t item_r;
  div_item_t item_nxt;
  logic      ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // One restoring-division step: try the shifted divisor, subtract it from the remainder if it fits.
  always_comb begin
    ge           = (up_item.rem >= mag_t'(up_item.dsh));
    item_nxt     = up_item;
    item_nxt.rem = ge ? (up_item.rem - mag_t'(up_item.dsh)) : up_item.rem;
    item_nxt.q   = {up_item.q[QUOT_W-2:0], ge};
    item_nxt.dsh = up_item.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

### rtl/bcd_back.sv
module bcd_back import bcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_item_t up_item,
  bcd_out_if.source out_chan
);

  logic   valid_r;
  depth_t depth_r, depth_nxt;
  logic   deg_r;
  quot_t  qm;
  sval_t  qs, sum, clamped;

  assign up_ready             = !valid_r || out_chan.ready;
  assign out_chan.valid       = valid_r;
  assign out_chan.depth_value = depth_r;
  assign out_chan.degenerate  = deg_r;

  always_comb begin
    qm = (up_item.ovf || (up_item.q > Q_CAP)) ? Q_CAP : up_item.q;
    qs = sval_t'({1'b0, qm});
    if (up_item.neg) begin
      qs = -qs;
    end
    sum = sval_t'(up_item.z2) + qs;
    priority if (sum > D_MAX) begin
      clamped = D_MAX;
    end else if (sum < D_MIN) begin
      clamped = D_MIN;
    end else begin
      clamped = sum;
    end
    depth_nxt = up_item.deg ? depth_t'(0) : depth_t'(clamped[DEPTH_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      depth_r <= depth_nxt;
      deg_r   <= up_item.deg;
    end
  end

endmodule

### rtl/bcd_checker.sv
module bcd_checker import bcd_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input depth_t out_depth,
  input logic   out_degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_depth) && $stable(out_degenerate))
    else $error("Result payload changed while stalled.");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_depth == '0)
    else $error("Degenerate result carries a nonzero depth.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output stage is empty.");

endmodule

bind barycentric_depth_interpolation bcd_checker u_bcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_depth      (out_chan.depth_value),
  .out_degenerate (out_chan.degenerate)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import bcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES = 40;
  localparam longint DEPTH_HI = (longint'(1) << (DEPTH_BITS - 1)) - 1;
  localparam longint DEPTH_LO = -DEPTH_HI - 1;

  typedef struct {
    coord_t vertex0_x;
    coord_t vertex0_y;
    depth_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    depth_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    depth_t vertex2_z;
    coord_t point_x;
    coord_t point_y;
  } triangle_query_t;

  typedef struct {
    depth_t depth_value;
    logic   degenerate;
  } depth_sample_t;

  typedef struct {
    triangle_query_t query;
    bit              by_hand;
    depth_sample_t   hand_result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bcd_in_if  in_chan ();
  bcd_out_if out_chan ();

  barycentric_depth_interpolation DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  depth_sample_t pending_depths[$];
  int mismatch_count = 0;
  int depths_seen = 0;
  int cycle_count = 0;
  bit held_long = 1'b0;

  directed_row_t directed_table [20] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 1'b1}},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      1'b1, '{0, 1'b1}},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        -32768, -32768}, 1'b1, '{0, 1'b1}},
    '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, '{0, 1'b1}},
    '{'{0, 0, 11, 1, 1, 22, 2, 2, 33, 5, 7}, 1'b1, '{0, 1'b1}},
    '{'{-5, 9, 300, 40, -2, -400, 40, -2, 17, 3, 3}, 1'b1, '{0, 1'b1}},
    '{'{0, 0, 1234, 1, 0, -77, 0, 1, 500, 0, 0}, 1'b1, '{1234, 1'b0}},
    '{'{0, 0, 1234, 1, 0, -77, 0, 1, 500, 1, 0}, 1'b1, '{-77, 1'b0}},
    '{'{0, 0, 1234, 1, 0, -77, 0, 1, 500, 0, 1}, 1'b1, '{500, 1'b0}},
    '{'{0, 0, 32767, 1, 0, 0, 0, 1, 0, -32768, -32768}, 1'b1, '{32767, 1'b0}},
    '{'{0, 0, -32768, 1, 0, 0, 0, 1, 0, -32768, -32768}, 1'b1, '{-32768, 1'b0}},
    '{'{32767, -32768, -1, -32768, -32768, 0, 32767, 32767, 1, 32767, -32768},
      1'b1, '{-1, 1'b0}},
    '{'{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0},
      1'b0, '{0, 1'b0}},
    '{'{0, 0, 100, 0, 3, 0, 3, 0, 7, 1, 1}, 1'b0, '{0, 1'b0}},
    '{'{0, 0, -10, 3, 0, 0, 0, 3, 0, 1, 1}, 1'b0, '{0, 1'b0}},
    '{'{0, 0, 10, 3, 0, 0, 0, 3, 0, 1, 1}, 1'b0, '{0, 1'b0}},
    '{'{-100, -100, 32767, 100, -100, -32768, 0, 100, 32767, 0, 0}, 1'b0, '{0, 1'b0}},
    '{'{10, 10, 5, 20, 10, 6, 10, 20, 7, 32767, -32768}, 1'b0, '{0, 1'b0}},
    '{'{-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768,
        32767, 32767}, 1'b0, '{0, 1'b0}},
    '{'{7, -3, -32768, -9, 12, 32767, 4, 8, -1, 2, 5}, 1'b0, '{0, 1'b0}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic depth_sample_t interpolate_depth(input triangle_query_t q);
    depth_sample_t sample;
    longint x0, y0, z0, x1, y1, z1, x2, y2, z2, px, py;
    longint area, w1, w2, weighted, level;
    x0 = q.vertex0_x;
    y0 = q.vertex0_y;
    z0 = q.vertex0_z;
    x1 = q.vertex1_x;
    y1 = q.vertex1_y;
    z1 = q.vertex1_z;
    x2 = q.vertex2_x;
    y2 = q.vertex2_y;
    z2 = q.vertex2_z;
    px = q.point_x;
    py = q.point_y;
    area = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
    w1 = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
    w2 = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
    if (area == 0) begin
      sample.depth_value = '0;
      sample.degenerate = 1'b1;
      return sample;
    end
    weighted = w1 * (z0 - z2) + w2 * (z1 - z2);
    level = z2 + weighted / area;
    if (level > DEPTH_HI) begin
      level = DEPTH_HI;
    end
    if (level < DEPTH_LO) begin
      level = DEPTH_LO;
    end
    sample.depth_value = depth_t'(level);
    sample.degenerate = 1'b0;
    return sample;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int edge_value(input int bits);
    case ($urandom_range(0, 4))
      0: return -(1 << (bits - 1));
      1: return (1 << (bits - 1)) - 1;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic depth_t random_depth();
    if ($urandom_range(0, 3) == 0) begin
      return depth_t'(edge_value(DEPTH_BITS));
    end
    return depth_t'($urandom);
  endfunction

  function automatic triangle_query_t random_query();
    triangle_query_t q;
    int kind, bx, by, dx, dy, a, b;
    kind = $urandom_range(0, 99);
    q.vertex0_z = random_depth();
    q.vertex1_z = random_depth();
    q.vertex2_z = random_depth();
    bx = span(-30000, 30000);
    by = span(-30000, 30000);
    q.point_x = coord_t'($urandom);
    q.point_y = coord_t'($urandom);
    if (kind < 25) begin
      q.vertex0_x = coord_t'($urandom);
      q.vertex0_y = coord_t'($urandom);
      q.vertex1_x = coord_t'($urandom);
      q.vertex1_y = coord_t'($urandom);
      q.vertex2_x = coord_t'($urandom);
      q.vertex2_y = coord_t'($urandom);
    end else if (kind < 35) begin
      dx = span(-100, 100);
      dy = span(-100, 100);
      a = span(-3, 3);
      b = span(-3, 3);
      q.vertex0_x = coord_t'(bx);
      q.vertex0_y = coord_t'(by);
      q.vertex1_x = coord_t'(bx + a * dx);
      q.vertex1_y = coord_t'(by + a * dy);
      q.vertex2_x = coord_t'(bx + b * dx);
      q.vertex2_y = coord_t'(by + b * dy);
    end else if (kind < 45) begin
      q.vertex0_x = coord_t'(edge_value(COORD_BITS));
      q.vertex0_y = coord_t'(edge_value(COORD_BITS));
      q.vertex1_x = coord_t'(edge_value(COORD_BITS));
      q.vertex1_y = coord_t'(edge_value(COORD_BITS));
      q.vertex2_x = coord_t'(edge_value(COORD_BITS));
      q.vertex2_y = coord_t'(edge_value(COORD_BITS));
      q.point_x = coord_t'(edge_value(COORD_BITS));
      q.point_y = coord_t'(edge_value(COORD_BITS));
    end else begin
      q.vertex0_x = coord_t'(bx + span(-300, 300));
      q.vertex0_y = coord_t'(by + span(-300, 300));
      q.vertex1_x = coord_t'(bx + span(-300, 300));
      q.vertex1_y = coord_t'(by + span(-300, 300));
      q.vertex2_x = coord_t'(bx + span(-300, 300));
      q.vertex2_y = coord_t'(by + span(-300, 300));
      if (kind < 88) begin
        q.point_x = coord_t'(bx + span(-400, 400));
        q.point_y = coord_t'(by + span(-400, 400));
      end
    end
    return q;
  endfunction

  task automatic offer_query(input triangle_query_t q, input depth_sample_t want);
    in_chan.valid <= 1'b1;
    in_chan.vertex0_x <= q.vertex0_x;
    in_chan.vertex0_y <= q.vertex0_y;
    in_chan.vertex0_z <= q.vertex0_z;
    in_chan.vertex1_x <= q.vertex1_x;
    in_chan.vertex1_y <= q.vertex1_y;
    in_chan.vertex1_z <= q.vertex1_z;
    in_chan.vertex2_x <= q.vertex2_x;
    in_chan.vertex2_y <= q.vertex2_y;
    in_chan.vertex2_z <= q.vertex2_z;
    in_chan.point_x <= q.point_x;
    in_chan.point_y <= q.point_y;
    do @(posedge clk); while (!in_chan.ready);
    pending_depths.push_back(want);
  endtask

  task automatic idle_sender(input bit no_gaps);
    int pick, gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (pick >= 95) begin
        gap = $urandom_range(15, 60);
      end else if (pick >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_depths.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    triangle_query_t q;
    depth_sample_t want;
    int waited;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.vertex0_x <= '0;
    in_chan.vertex0_y <= '0;
    in_chan.vertex0_z <= '0;
    in_chan.vertex1_x <= '0;
    in_chan.vertex1_y <= '0;
    in_chan.vertex1_z <= '0;
    in_chan.vertex2_x <= '0;
    in_chan.vertex2_y <= '0;
    in_chan.vertex2_z <= '0;
    in_chan.point_x <= '0;
    in_chan.point_y <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_table[i]) begin
      if (directed_table[i].by_hand) begin
        want = directed_table[i].hand_result;
      end else begin
        want = interpolate_depth(directed_table[i].query);
      end
      offer_query(directed_table[i].query, want);
      idle_sender(1'b0);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) begin
        drain_results();
      end
      q = random_query();
      offer_query(q, interpolate_depth(q));
      idle_sender(i >= 100 && i < 160);
    end
    in_chan.valid <= 1'b0;

    waited = 0;
    while (pending_depths.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_depths.size() != 0) begin
      $error("%0d requests never produced a result", pending_depths.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    int pick;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_long && depths_seen >= 150) begin
        held_long = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (pick < 95) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    depth_sample_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      depths_seen++;
      if (pending_depths.size() == 0) begin
        $error("result with no request outstanding: depth_value %0d, degenerate %0b",
               out_chan.depth_value, out_chan.degenerate);
        mismatch_count++;
      end else begin
        want = pending_depths.pop_front();
        if (out_chan.depth_value !== want.depth_value) begin
          $error("depth_value: expected %0d, got %0d", want.depth_value,
                 out_chan.depth_value);
          mismatch_count++;
        end
        if (out_chan.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate,
                 out_chan.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/bcd_pkg.sv
rtl/bcd_in_if.sv
rtl/bcd_out_if.sv
rtl/bcd_front.sv
rtl/bcd_div_cell.sv
rtl/bcd_back.sv
rtl/barycentric_depth_interpolation.sv
rtl/bcd_checker.sv
tb/tb.sv
